FILE: rtl/vpa_pkg.sv
// Package for the variable partition allocator.
// Holds default sizes, field widths, status codes and the sequencer states.
// No dependencies.
package vpa_pkg;

  localparam int MEMORY_UNITS   = 1024;
  localparam int MAX_PARTITIONS = 32;
  localparam int OWNER_W        = 8;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_NO_HOLE  = 3'd1,
    ST_NO_OWNER = 3'd2,
    ST_FULL     = 3'd3,
    ST_ZERO     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT_UP,
    S_WR_HI,
    S_WR_PICK,
    S_RD_NEXT,
    S_RD_PREV,
    S_MERGE,
    S_SHIFT_DN,
    S_RESULT
  } state_t;

endpackage

FILE: rtl/vpa_req_if.sv
// Request channel of the partition allocator: valid/ready plus one request item.
// Depends on vpa_pkg for the owner width.
interface vpa_req_if #(
  parameter int LEN_W = 11
);
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [vpa_pkg::OWNER_W-1:0] request_owner;
  logic [LEN_W-1:0]            request_size;

  modport source (output valid, output mode, output request_owner, output request_size,
                  input ready);
  modport sink   (input valid, input mode, input request_owner, input request_size,
                  output ready);
endinterface

FILE: rtl/vpa_rsp_if.sv
// Response channel of the partition allocator: valid/ready plus one result item.
// No dependencies.
interface vpa_rsp_if #(
  parameter int BASE_W = 10,
  parameter int LEN_W  = 11
);
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [BASE_W-1:0] granted_base;
  logic [LEN_W-1:0]  released_length;

  modport source (output valid, output status, output granted_base, output released_length,
                  input ready);
  modport sink   (input valid, input status, input granted_base, input released_length,
                  output ready);
endinterface

FILE: rtl/variable_partition_allocator.sv
// Variable partition allocator, first fit / best fit, over an address-ordered table.
// One item at a time. Allocate scans the table and, when a hole is split, shifts the entries
// above the pick up; a zero size skips the scan. Release scans, then merges the freed entry
// with a free neighbor and shifts the entries above down. Ready again once the result is in
// the output register. Reset: the init state writes the whole-memory entry, policy best fit.
module variable_partition_allocator #(
  parameter int MEMORY_UNITS   = vpa_pkg::MEMORY_UNITS,
  parameter int MAX_PARTITIONS = vpa_pkg::MAX_PARTITIONS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  vpa_req_if.sink     req,
  vpa_rsp_if.source   rsp
);

  localparam int BASE_W = $clog2(MEMORY_UNITS);
  localparam int LEN_W  = $clog2(MEMORY_UNITS + 1);
  localparam int IW     = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CW     = $clog2(MAX_PARTITIONS + 1);

  typedef struct packed {
    logic [BASE_W-1:0]           base;
    logic [LEN_W-1:0]            len;
    logic                        used;
    logic [vpa_pkg::OWNER_W-1:0] owner;
  } entry_t;

  entry_t mem [MAX_PARTITIONS];
  entry_t rd_data;
  entry_t wr_data;
  logic [IW-1:0] rd_addr, wr_addr;
  logic          we;

  vpa_pkg::state_t state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   i, i_next;
  logic            rv, rv_next;
  logic [IW-1:0]   ridx, ridx_next;
  logic            wv, wv_next;
  logic [IW-1:0]   wa, wa_next;
  logic            found, found_next;
  logic [IW-1:0]   pick_idx, pick_idx_next;
  logic [BASE_W-1:0] pick_base, pick_base_next;
  logic [LEN_W-1:0]  pick_len, pick_len_next;
  logic            nfree, nfree_next;
  logic [LEN_W-1:0] nlen, nlen_next;
  logic [1:0]      r, r_next;
  logic            fit_policy;

  logic                        req_mode, req_mode_next;
  logic [vpa_pkg::OWNER_W-1:0] req_owner, req_owner_next;
  logic [LEN_W-1:0]            req_size, req_size_next;

  vpa_pkg::status_t  res_status, res_status_next;
  logic [BASE_W-1:0] res_base, res_base_next;
  logic [LEN_W-1:0]  res_rel, res_rel_next;

  logic              out_valid, out_valid_next;
  vpa_pkg::status_t  out_status, out_status_next;
  logic [BASE_W-1:0] out_base, out_base_next;
  logic [LEN_W-1:0]  out_rel, out_rel_next;

  // scratch values for the sequencer
  logic          hit, better, pfree, has_next;
  logic [CW-1:0] i_dec;
  logic [CW:0]   src_idx;
  logic [IW-1:0] start;
  logic [LEN_W-1:0] merged;
  logic [BASE_W-1:0] sbase;

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= vpa_pkg::S_INIT;
      count      <= CW'(1);
      rv         <= 1'b0;
      wv         <= 1'b0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
      fit_policy <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rv        <= rv_next;
      wv        <= wv_next;
      found     <= found_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        fit_policy <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    i          <= i_next;
    ridx       <= ridx_next;
    wa         <= wa_next;
    pick_idx   <= pick_idx_next;
    pick_base  <= pick_base_next;
    pick_len   <= pick_len_next;
    nfree      <= nfree_next;
    nlen       <= nlen_next;
    r          <= r_next;
    req_mode   <= req_mode_next;
    req_owner  <= req_owner_next;
    req_size   <= req_size_next;
    res_status <= res_status_next;
    res_base   <= res_base_next;
    res_rel    <= res_rel_next;
    out_status <= out_status_next;
    out_base   <= out_base_next;
    out_rel    <= out_rel_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    i_next          = i;
    rv_next         = rv;
    ridx_next       = ridx;
    wv_next         = wv;
    wa_next         = wa;
    found_next      = found;
    pick_idx_next   = pick_idx;
    pick_base_next  = pick_base;
    pick_len_next   = pick_len;
    nfree_next      = nfree;
    nlen_next       = nlen;
    r_next          = r;
    req_mode_next   = req_mode;
    req_owner_next  = req_owner;
    req_size_next   = req_size;
    res_status_next = res_status;
    res_base_next   = res_base;
    res_rel_next    = res_rel;
    out_valid_next  = out_valid;
    out_status_next = out_status;
    out_base_next   = out_base;
    out_rel_next    = out_rel;
    rd_addr         = '0;
    we              = 1'b0;
    wr_addr         = '0;
    wr_data         = '0;

    hit      = req_mode ? (!rd_data.used && (rd_data.len >= req_size))
                        : (rd_data.used && (rd_data.owner == req_owner));
    better   = !found || (req_mode && !fit_policy && (rd_data.len < pick_len));
    i_dec    = i - 1'b1;
    src_idx  = (CW+1)'(i) + (CW+1)'(r);
    has_next = ((CW+1)'(pick_idx) + 1'b1) < (CW+1)'(count);
    pfree    = (pick_idx != '0) && !rd_data.used;
    start    = pfree ? (pick_idx - 1'b1) : pick_idx;
    sbase    = pfree ? rd_data.base : pick_base;
    merged   = (pfree ? rd_data.len : '0) + pick_len + (nfree ? nlen : '0);

    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      vpa_pkg::S_INIT: begin
        we           = 1'b1;
        wr_data.len  = LEN_W'(MEMORY_UNITS);
        state_next   = vpa_pkg::S_IDLE;
      end
      vpa_pkg::S_IDLE: begin
        if (req.valid) begin
          req_mode_next  = req.mode;
          req_owner_next = req.request_owner;
          req_size_next  = req.request_size;
          found_next     = 1'b0;
          i_next         = '0;
          rv_next        = 1'b0;
          res_base_next  = '0;
          res_rel_next   = '0;
          if (req.mode && (req.request_size == '0)) begin
            res_status_next = vpa_pkg::ST_ZERO;
            state_next      = vpa_pkg::S_RESULT;
          end else begin
            state_next = vpa_pkg::S_SCAN;
          end
        end
      end
      vpa_pkg::S_SCAN: begin
        // read one entry per cycle, judge it the cycle after
        if (rv && hit && better) begin
          found_next     = 1'b1;
          pick_idx_next  = ridx;
          pick_base_next = rd_data.base;
          pick_len_next  = rd_data.len;
        end
        if (i < count) begin
          rd_addr   = i[IW-1:0];
          rv_next   = 1'b1;
          ridx_next = i[IW-1:0];
          i_next    = i + 1'b1;
        end else begin
          rv_next = 1'b0;
          if (!rv) begin
            state_next = vpa_pkg::S_DECIDE;
          end
        end
      end
      vpa_pkg::S_DECIDE: begin
        if (!found) begin
          res_status_next = req_mode ? vpa_pkg::ST_NO_HOLE : vpa_pkg::ST_NO_OWNER;
          state_next      = vpa_pkg::S_RESULT;
        end else if (!req_mode) begin
          state_next = vpa_pkg::S_RD_NEXT;
        end else if (pick_len == req_size) begin
          state_next = vpa_pkg::S_WR_PICK;
        end else if (count >= CW'(MAX_PARTITIONS)) begin
          res_status_next = vpa_pkg::ST_FULL;
          state_next      = vpa_pkg::S_RESULT;
        end else begin
          wv_next    = 1'b0;
          i_next     = count;
          state_next = vpa_pkg::S_SHIFT_UP;
        end
      end
      vpa_pkg::S_SHIFT_UP: begin
        // move entries above the pick up by one, top first
        if (wv) begin
          we      = 1'b1;
          wr_addr = wa;
          wr_data = rd_data;
        end
        if ((CW+1)'(i) > ((CW+1)'(pick_idx) + 1'b1)) begin
          rd_addr = i_dec[IW-1:0];
          wv_next = 1'b1;
          wa_next = i[IW-1:0];
          i_next  = i_dec;
        end else begin
          wv_next = 1'b0;
          if (!wv) begin
            state_next = vpa_pkg::S_WR_HI;
          end
        end
      end
      vpa_pkg::S_WR_HI: begin
        we           = 1'b1;
        wr_addr      = pick_idx + 1'b1;
        wr_data.base = BASE_W'(pick_base + req_size);
        wr_data.len  = pick_len - req_size;
        count_next   = count + 1'b1;
        state_next   = vpa_pkg::S_WR_PICK;
      end
      vpa_pkg::S_WR_PICK: begin
        we              = 1'b1;
        wr_addr         = pick_idx;
        wr_data.base    = pick_base;
        wr_data.len     = req_size;
        wr_data.used    = 1'b1;
        wr_data.owner   = req_owner;
        res_status_next = vpa_pkg::ST_DONE;
        res_base_next   = pick_base;
        state_next      = vpa_pkg::S_RESULT;
      end
      vpa_pkg::S_RD_NEXT: begin
        rd_addr    = pick_idx + 1'b1;
        state_next = vpa_pkg::S_RD_PREV;
      end
      vpa_pkg::S_RD_PREV: begin
        nfree_next = has_next && !rd_data.used;
        nlen_next  = rd_data.len;
        rd_addr    = pick_idx - 1'b1;
        state_next = vpa_pkg::S_MERGE;
      end
      vpa_pkg::S_MERGE: begin
        // one merged free entry at start; r entries above it close the gap
        we              = 1'b1;
        wr_addr         = start;
        wr_data.base    = sbase;
        wr_data.len     = merged;
        r_next          = {1'b0, pfree} + {1'b0, nfree};
        res_status_next = vpa_pkg::ST_DONE;
        res_base_next   = pick_base;
        res_rel_next    = pick_len;
        i_next          = CW'(start) + 1'b1;
        wv_next         = 1'b0;
        if (!pfree && !nfree) begin
          state_next = vpa_pkg::S_RESULT;
        end else begin
          state_next = vpa_pkg::S_SHIFT_DN;
        end
      end
      vpa_pkg::S_SHIFT_DN: begin
        if (wv) begin
          we      = 1'b1;
          wr_addr = wa;
          wr_data = rd_data;
        end
        if (src_idx < (CW+1)'(count)) begin
          rd_addr = src_idx[IW-1:0];
          wv_next = 1'b1;
          wa_next = i[IW-1:0];
          i_next  = i + 1'b1;
        end else begin
          wv_next = 1'b0;
          if (!wv) begin
            count_next = count - CW'(r);
            state_next = vpa_pkg::S_RESULT;
          end
        end
      end
      vpa_pkg::S_RESULT: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_base_next   = res_base;
          out_rel_next    = res_rel;
          state_next      = vpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = vpa_pkg::S_INIT;
      end
    endcase
  end

  assign req.ready           = (state == vpa_pkg::S_IDLE);
  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.granted_base    = out_base;
  assign rsp.released_length = out_rel;

`ifndef NO_ASSERTIONS
  a_load_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == vpa_pkg::S_RESULT))
    else $error("result item appeared outside the result step");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != vpa_pkg::S_IDLE))
    else $error("sequencer stayed idle after taking an item");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count >= CW'(1)) && (count <= CW'(MAX_PARTITIONS)))
    else $error("partition count out of range");

  a_full_no_grow: assert property (@(posedge clk) disable iff (rst)
    (state == vpa_pkg::S_WR_HI) |-> ($past(count) < CW'(MAX_PARTITIONS)))
    else $error("split attempted on a full table");
`endif

endmodule
